// ----- hdl/ltrd_pkg.sv -----
package ltrd_pkg;

  localparam int CNT_W = 24;
  localparam int WORD_W = 36;
  localparam int CHAR_W = 6;
  localparam int KIND_W = 3;
  localparam int WL_W = 18;
  localparam int WIB_W = 9;
  localparam int WORDS_PER_BLOCK = 433;

  localparam logic [7:0] TAPE_MARK = 8'o217;
  localparam logic [WORD_W-1:0] LABEL_WORD = 36'o272560600600;
  localparam logic [WORD_W-1:0] EOF_WORD = 36'o606025462660;
  localparam logic [WORD_W-1:0] EOT_WORD = 36'o602546436360;

  localparam logic [KIND_W-1:0] K_DATA = 3'd0;
  localparam logic [KIND_W-1:0] K_NEWLINE = 3'd1;
  localparam logic [KIND_W-1:0] K_FORMFEED = 3'd2;
  localparam logic [KIND_W-1:0] K_LABEL = 3'd3;
  localparam logic [KIND_W-1:0] K_REPORT = 3'd4;
  localparam logic [KIND_W-1:0] K_ERROR = 3'd5;

  // everything one tape byte asks the output side to produce
  typedef struct packed {
    logic              has_word;
    logic [KIND_W-1:0] word_kind;
    logic [WORD_W-1:0] word;
    logic              s0_valid;
    logic [KIND_W-1:0] s0_kind;
    logic              s1_valid;
    logic [KIND_W-1:0] s1_kind;
    logic [CNT_W-1:0]  files_a;
    logic [CNT_W-1:0]  files_b;
    logic [CNT_W-1:0]  blocks;
    logic [CNT_W-1:0]  records;
  } cmd_t;

endpackage

// ----- hdl/ltrd_front.sv -----
module ltrd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          list_mode,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_tape_char,
  input  logic          in_end_of_input,
  input  logic          q_full,
  output logic          q_push,
  output ltrd_pkg::cmd_t q_cmd
);
  import ltrd_pkg::*;

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_LABEL_LIST = 3'd1;
  localparam logic [2:0] PH_LABEL_SKIP = 3'd2;
  localparam logic [2:0] PH_BLOCK_HEAD = 3'd3;
  localparam logic [2:0] PH_BLOCK_DATA = 3'd4;
  localparam logic [2:0] PH_EOF_SKIP = 3'd5;
  localparam logic [2:0] PH_EOT_SKIP = 3'd6;
  localparam logic [2:0] PH_HALTED = 3'd7;

  localparam logic [WIB_W-1:0] WIB_LAST = WIB_W'(WORDS_PER_BLOCK - 1);
  localparam int ACC_W = WORD_W - CHAR_W;

  logic [2:0]       phase_r, phase_nxt;
  logic [2:0]       chars_r, chars_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             inside_r, inside_nxt;
  logic [WL_W-1:0]  wl_r, wl_nxt;
  logic [WIB_W-1:0] wib_r, wib_nxt;
  logic [CNT_W-1:0] files_r, files_nxt;
  logic [CNT_W-1:0] blocks_r, blocks_nxt;
  logic [CNT_W-1:0] recs_r, recs_nxt;

  logic [WORD_W-1:0] w;
  logic [WL_W-1:0]   wl_dec;
  logic [WIB_W-1:0]  wib_inc;
  logic              accept;
  logic              nl_old_files;
  cmd_t              cmd;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    sat_inc = (&x) ? x : x + CNT_W'(1);
  endfunction

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign w = {acc_r, in_tape_char[CHAR_W-1:0]};
  assign wl_dec = wl_r - WL_W'(1);
  assign wib_inc = wib_r + WIB_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    chars_nxt = chars_r;
    acc_nxt = acc_r;
    inside_nxt = inside_r;
    wl_nxt = wl_r;
    wib_nxt = wib_r;
    files_nxt = files_r;
    blocks_nxt = blocks_r;
    recs_nxt = recs_r;
    nl_old_files = 1'b0;
    cmd = '0;
    cmd.word = w;
    if (phase_r == PH_HALTED) begin
      // ignore everything
    end else if (in_end_of_input) begin
      chars_nxt = '0;
      acc_nxt = '0;
      if (phase_r == PH_EOT_SKIP) begin
        cmd.s0_valid = 1'b1;
        cmd.s0_kind = K_REPORT;
      end else begin
        if (phase_r == PH_LABEL_LIST) begin
          cmd.s0_valid = 1'b1;
          cmd.s0_kind = K_NEWLINE;
          nl_old_files = 1'b1;
          files_nxt = sat_inc(files_r);
          inside_nxt = 1'b0;
        end else if (phase_r == PH_LABEL_SKIP) begin
          files_nxt = sat_inc(files_r);
          inside_nxt = 1'b0;
        end else if (phase_r == PH_EOF_SKIP && !list_mode) begin
          cmd.s0_valid = 1'b1;
          cmd.s0_kind = K_FORMFEED;
        end
        if (cmd.s0_valid) begin
          cmd.s1_valid = 1'b1;
          cmd.s1_kind = K_ERROR;
        end else begin
          cmd.s0_valid = 1'b1;
          cmd.s0_kind = K_ERROR;
        end
      end
      phase_nxt = PH_HALTED;
    end else if (in_tape_char == TAPE_MARK) begin
      chars_nxt = '0;
      acc_nxt = '0;
      unique case (phase_r)
        PH_FIRST: begin
          cmd.s0_valid = 1'b1;
          cmd.s0_kind = K_ERROR;
          phase_nxt = PH_HALTED;
        end
        PH_LABEL_LIST: begin
          cmd.s0_valid = 1'b1;
          cmd.s0_kind = K_NEWLINE;
          nl_old_files = 1'b1;
          files_nxt = sat_inc(files_r);
          inside_nxt = 1'b0;
          phase_nxt = PH_BLOCK_HEAD;
        end
        PH_LABEL_SKIP: begin
          files_nxt = sat_inc(files_r);
          inside_nxt = 1'b0;
          phase_nxt = PH_BLOCK_HEAD;
        end
        PH_BLOCK_HEAD, PH_BLOCK_DATA: begin
          phase_nxt = PH_FIRST;
        end
        PH_EOF_SKIP: begin
          cmd.s0_valid = !list_mode;
          cmd.s0_kind = K_FORMFEED;
          phase_nxt = PH_FIRST;
        end
        PH_EOT_SKIP: begin
          cmd.s0_valid = 1'b1;
          cmd.s0_kind = K_REPORT;
          phase_nxt = PH_HALTED;
        end
        default: begin
        end
      endcase
    end else if (phase_r == PH_FIRST || phase_r == PH_LABEL_LIST ||
                 phase_r == PH_BLOCK_HEAD || phase_r == PH_BLOCK_DATA) begin
      if (chars_r != 3'd5) begin
        acc_nxt = w[ACC_W-1:0];
        chars_nxt = chars_r + 3'd1;
      end else begin
        // sixth character completes a word
        chars_nxt = '0;
        acc_nxt = '0;
        unique case (phase_r)
          PH_FIRST: begin
            if (w == LABEL_WORD) begin
              if (list_mode) begin
                cmd.has_word = 1'b1;
                cmd.word_kind = K_LABEL;
                phase_nxt = PH_LABEL_LIST;
              end else begin
                phase_nxt = PH_LABEL_SKIP;
              end
            end else if (w == EOF_WORD) begin
              phase_nxt = PH_EOF_SKIP;
            end else if (w == EOT_WORD) begin
              phase_nxt = PH_EOT_SKIP;
            end else begin
              cmd.s0_valid = 1'b1;
              cmd.s0_kind = K_ERROR;
              phase_nxt = PH_HALTED;
            end
          end
          PH_LABEL_LIST: begin
            cmd.has_word = 1'b1;
            cmd.word_kind = K_LABEL;
          end
          PH_BLOCK_HEAD: begin
            blocks_nxt = sat_inc(blocks_r);
            wib_nxt = '0;
            phase_nxt = PH_BLOCK_DATA;
          end
          default: begin
            if (inside_r) begin
              cmd.has_word = !list_mode;
              cmd.word_kind = K_DATA;
              wl_nxt = wl_dec;
              if (wl_dec == '0) begin
                inside_nxt = 1'b0;
                cmd.s0_valid = !list_mode;
                cmd.s0_kind = K_NEWLINE;
              end
            end else if (w[WORD_W-1:WL_W] != '0) begin
              // record header with its word count
              recs_nxt = sat_inc(recs_r);
              wl_nxt = w[WL_W-1:0];
              if (w[WL_W-1:0] != '0) begin
                inside_nxt = 1'b1;
              end else begin
                cmd.s0_valid = !list_mode;
                cmd.s0_kind = K_NEWLINE;
              end
            end
            wib_nxt = wib_inc;
            if (wib_inc >= WIB_LAST) begin
              phase_nxt = PH_BLOCK_HEAD;
            end
          end
        endcase
      end
    end
    cmd.files_a = nl_old_files ? files_r : files_nxt;
    cmd.files_b = files_nxt;
    cmd.blocks = blocks_nxt;
    cmd.records = recs_nxt;
  end

  assign q_cmd = cmd;
  assign q_push = accept && (cmd.has_word || cmd.s0_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      chars_r <= '0;
      acc_r <= '0;
      inside_r <= 1'b0;
      wl_r <= '0;
      wib_r <= '0;
      files_r <= '0;
      blocks_r <= '0;
      recs_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      chars_r <= chars_nxt;
      acc_r <= acc_nxt;
      inside_r <= inside_nxt;
      wl_r <= wl_nxt;
      wib_r <= wib_nxt;
      files_r <= files_nxt;
      blocks_r <= blocks_nxt;
      recs_r <= recs_nxt;
    end
  end

endmodule

// ----- hdl/ltrd_queue.sv -----
module ltrd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ltrd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ltrd_pkg::cmd_t head
);
  import ltrd_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hdl/ltrd_back.sv -----
module ltrd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  ltrd_pkg::cmd_t                 q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ltrd_pkg::KIND_W-1:0]    out_kind,
  output logic [ltrd_pkg::CHAR_W-1:0]    out_char_code,
  output logic [ltrd_pkg::CNT_W-1:0]     out_files_seen,
  output logic [ltrd_pkg::CNT_W-1:0]     out_blocks_seen,
  output logic [ltrd_pkg::CNT_W-1:0]     out_records_seen,
  output logic                           out_last
);
  import ltrd_pkg::*;

  // steps 0..5 are the word's characters, 6 and 7 the two single results
  localparam logic [2:0] STEP_LAST_CHAR = 3'd5;
  localparam logic [2:0] STEP_S0 = 3'd6;
  localparam logic [2:0] STEP_S1 = 3'd7;

  cmd_t       cur_r, cur_nxt;
  logic       busy_r, busy_nxt;
  logic [2:0] step_r, step_nxt;
  logic       done;
  logic       take;
  logic       is_char;

  assign is_char = (step_r <= STEP_LAST_CHAR);

  always_comb begin
    unique case (step_r)
      STEP_S0: out_last = !cur_r.s1_valid;
      STEP_S1: out_last = 1'b1;
      default: out_last = (step_r == STEP_LAST_CHAR) && !cur_r.s0_valid;
    endcase
  end

  always_comb begin
    unique case (step_r)
      3'd0: out_char_code = cur_r.word[35:30];
      3'd1: out_char_code = cur_r.word[29:24];
      3'd2: out_char_code = cur_r.word[23:18];
      3'd3: out_char_code = cur_r.word[17:12];
      3'd4: out_char_code = cur_r.word[11:6];
      3'd5: out_char_code = cur_r.word[5:0];
      default: out_char_code = '0;
    endcase
  end

  assign out_valid = busy_r;
  assign out_kind = is_char ? cur_r.word_kind :
                    (step_r == STEP_S0) ? cur_r.s0_kind : cur_r.s1_kind;
  assign out_files_seen = (step_r == STEP_S1) ? cur_r.files_b : cur_r.files_a;
  assign out_blocks_seen = cur_r.blocks;
  assign out_records_seen = cur_r.records;

  assign done = busy_r && !out_stall;
  assign take = (!busy_r || (done && out_last)) && !q_empty;
  assign q_pop = take;

  always_comb begin
    cur_nxt = cur_r;
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (take) begin
      cur_nxt = q_head;
      busy_nxt = 1'b1;
      step_nxt = q_head.has_word ? 3'd0 : STEP_S0;
    end else if (done && out_last) begin
      busy_nxt = 1'b0;
    end else if (done) begin
      step_nxt = (step_r == STEP_LAST_CHAR) ? STEP_S0 : step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

// ----- hdl/label_tape_record_deframer.sv -----
// an accepted byte's results pass through the command queue and then the output register before they are offered
// throughput: one byte accepted per cycle while the two-entry command queue has room
// the output side gives one result per cycle while out_stall is low; a completed word gives up to seven,
// so a steady stream of data words can outrun the output side and stall the input through the queue
// reset: synchronous, active low; clears control state and counters, no clearing pass
module label_tape_record_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_tape_char,
  input  logic                        in_end_of_input,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ltrd_pkg::KIND_W-1:0] out_kind,
  output logic [ltrd_pkg::CHAR_W-1:0] out_char_code,
  output logic [ltrd_pkg::CNT_W-1:0]  out_files_seen,
  output logic [ltrd_pkg::CNT_W-1:0]  out_blocks_seen,
  output logic [ltrd_pkg::CNT_W-1:0]  out_records_seen,
  output logic                        out_last
);
  import ltrd_pkg::*;

  logic list_mode_r;
  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      list_mode_r <= cfg_wr_data;
    end
  end

  ltrd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .list_mode       (list_mode_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tape_char    (in_tape_char),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  ltrd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  ltrd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_char_code    (out_char_code),
    .out_files_seen   (out_files_seen),
    .out_blocks_seen  (out_blocks_seen),
    .out_records_seen (out_records_seen),
    .out_last         (out_last)
  );

endmodule
